>>> hw/rtl/wfg_pkg.sv
// Shared types, constants and graph helpers for the wait-for graph cycle detector.
package wfg_pkg;

  localparam int NODES   = 8;
  localparam int NODE_W  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int RND_W   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef logic [NODES-1:0]            row_t;
  typedef logic [NODES-1:0][NODES-1:0] matrix_t;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_NOP   = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [NODE_W-1:0] row;
    logic [NODE_W-1:0] col;
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_PEEL = 2'd1,
    BK_HOLD = 2'd2
  } bk_state_t;

  // Apply one graph update to the edge matrix.
  function automatic matrix_t apply_op(input matrix_t rows, input op_t op);
    matrix_t res;
    res = rows;
    for (int u = 0; u < NODES; u++) begin
      if (op.row == NODE_W'(u)) begin
        case (op.kind)
          OP_ADD:   res[u] = rows[u] | (row_t'(1) << op.col);
          OP_CLEAR: res[u] = '0;
          default:  res[u] = rows[u];
        endcase
      end
    end
    return res;
  endfunction

  // One peeling round: drop every live node with no edge into the live set.
  function automatic row_t peel(input matrix_t rows, input row_t alive);
    row_t res;
    for (int u = 0; u < NODES; u++) begin
      res[u] = alive[u] & (|(rows[u] & alive));
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/wfg_front.sv
// Front end: accepts event words and classifies them into graph operations.
module wfg_front (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_cmd,
  input  logic [2:0]                in_waiter,
  input  logic [2:0]                in_owner,
  input  logic                      q_full,
  output logic                      push,
  output wfg_pkg::op_t              push_op
);

  logic waiter_ok;
  logic owner_ok;

  assign waiter_ok = (32'(in_waiter) < wfg_pkg::NODES);
  assign owner_ok  = (32'(in_owner) < wfg_pkg::NODES);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // out-of-range indices leave the graph alone but still yield a report
  always_comb begin
    push_op.row = wfg_pkg::NODE_W'(in_waiter);
    push_op.col = wfg_pkg::NODE_W'(in_owner);
    if (!waiter_ok) begin
      push_op.kind = wfg_pkg::OP_NOP;
    end else if (in_cmd) begin
      push_op.kind = wfg_pkg::OP_CLEAR;
    end else if (owner_ok) begin
      push_op.kind = wfg_pkg::OP_ADD;
    end else begin
      push_op.kind = wfg_pkg::OP_NOP;
    end
  end

endmodule

>>> hw/rtl/wfg_queue.sv
// Short operation queue between the front end and the graph engine.
module wfg_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  wfg_pkg::op_t push_op,
  input  logic         pop,
  output logic         q_valid,
  output logic         q_full,
  output wfg_pkg::op_t q_op
);

  wfg_pkg::op_t                      mem_r [wfg_pkg::Q_DEPTH];
  logic [wfg_pkg::Q_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [wfg_pkg::Q_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [wfg_pkg::Q_CNT_W-1:0]       cnt_r, cnt_nxt;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == wfg_pkg::Q_CNT_W'(wfg_pkg::Q_DEPTH));
  assign q_op    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

>>> hw/rtl/wfg_back.sv
// Graph engine: holds the edge matrix, applies updates and runs the cycle test.
module wfg_back (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  wfg_pkg::op_t q_op,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         out_cycle_found
);

  wfg_pkg::bk_state_t          state_r, state_nxt;
  wfg_pkg::matrix_t            rows_r, rows_nxt;
  wfg_pkg::row_t               alive_r, alive_nxt, alive_peel;
  logic [wfg_pkg::RND_W-1:0]   cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_bit_r, out_bit_nxt;
  logic                        out_free, last_rnd;
  logic                        start, step, load;
  logic                        load_bit;

  assign alive_peel = wfg_pkg::peel(rows_r, alive_r);
  assign out_free   = !out_valid_r || !out_stall;
  assign last_rnd   = (cnt_r == wfg_pkg::RND_W'(wfg_pkg::NODES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wfg_pkg::BK_IDLE: if (q_valid) state_nxt = wfg_pkg::BK_PEEL;
      wfg_pkg::BK_PEEL: begin
        if (last_rnd) state_nxt = out_free ? wfg_pkg::BK_IDLE : wfg_pkg::BK_HOLD;
      end
      wfg_pkg::BK_HOLD: if (out_free) state_nxt = wfg_pkg::BK_IDLE;
      default:          state_nxt = wfg_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop      = 1'b0;
    start    = 1'b0;
    step     = 1'b0;
    load     = 1'b0;
    load_bit = 1'b0;
    case (state_r)
      wfg_pkg::BK_IDLE: begin
        pop   = q_valid;
        start = q_valid;
      end
      wfg_pkg::BK_PEEL: begin
        step     = 1'b1;
        load     = last_rnd && out_free;
        load_bit = |alive_peel;
      end
      wfg_pkg::BK_HOLD: begin
        load     = out_free;
        load_bit = |alive_r;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    rows_nxt      = start ? wfg_pkg::apply_op(rows_r, q_op) : rows_r;
    alive_nxt     = start ? '1 : (step ? alive_peel : alive_r);
    cnt_nxt       = start ? '0 : (step ? cnt_r + 1'b1 : cnt_r);
    out_bit_nxt   = load ? load_bit : out_bit_r;
    out_valid_nxt = load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wfg_pkg::BK_IDLE;
      rows_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    alive_r   <= alive_nxt;
    out_bit_r <= out_bit_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_cycle_found = out_bit_r;

endmodule

>>> hw/rtl/wait_for_graph_cycle_detector.sv
// Top level of the wait-for graph cycle detector.
//
// Input channel (in_valid / in_stall): one event word per handshake.
//   in_cmd = 0 adds the edge in_waiter -> in_owner, in_cmd = 1 clears every
//   edge leaving in_waiter. An index >= NODES (owner on adds only) voids the event.
// Result channel (out_valid / out_stall): one word per event, in order;
//   out_cycle_found is 1 when the updated graph holds a directed cycle
//   (self-loops included).
// Path of an event: it waits in the queue until the engine takes the word and
//   applies the update; then come NODES peeling rounds of the shared row-AND/OR
//   step, the last of which also loads the output register unless it is stalled.
// The peeling loop in the graph engine works on one event at a time and pops
//   the next event only after the result of the last has been loaded.
// A two-word queue sits between front end and engine, so in_stall rises
//   only when that queue is full.
// Receiver stall: the result word holds in the output register; the engine
//   waits at the end of its test and the queue keeps filling until full.
// Reset (rst_n low, synchronous): edge matrix cleared, queue emptied,
//   no result pending.
module wait_for_graph_cycle_detector (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [2:0] in_waiter,
  input  logic [2:0] in_owner,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_cycle_found
);

  logic         push, pop, q_valid, q_full;
  wfg_pkg::op_t push_op, q_op;

  // classify events
  wfg_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_waiter (in_waiter),
    .in_owner  (in_owner),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  // decouple front end from engine
  wfg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .q_op    (q_op)
  );

  // matrix update and sink peeling
  wfg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_op            (q_op),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cycle_found (out_cycle_found)
  );

endmodule

>>> hw/rtl/wfg_checker.sv
// Port-level checker for the wait-for graph cycle detector, bound to the top level.
module wfg_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_cycle_found
);

  localparam int LIMIT = wfg_pkg::Q_DEPTH + 2;

  logic [wfg_pkg::Q_CNT_W:0] pend_r, pend_nxt;
  logic                      in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cycle_found))
    else $error("result word changed under stall");

  // no result word without an event behind it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result word with no event outstanding");

  // words in flight bounded by queue, engine and output register
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pend_r) <= LIMIT)
    else $error("too many events outstanding");

  // input is held back only once the queue holds a full load
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> 32'(pend_r) >= wfg_pkg::Q_DEPTH)
    else $error("input stalled with queue not full");

endmodule

bind wait_for_graph_cycle_detector wfg_checker u_wfg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_cycle_found (out_cycle_found)
);

>>> sim/wait_for_graph_cycle_detector_test.sv
// Self-checking testbench for the wait-for graph cycle detector.
module wait_for_graph_cycle_detector_test;

  // Event command codes carried on in_cmd.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Long receiver hold-off used to fill the block and push back on the sender.
  localparam int HOLD_CYCLES = 400;
  // Cycles with no word moving on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 3000;
  // Words per phase, the directed words of phase 0 included.
  localparam int PHASE_WORDS = 270;
  localparam int DIR_N       = 21;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_cmd    = CMD_ADD;
  logic [2:0] in_waiter = 3'd0;
  logic [2:0] in_owner  = 3'd0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_cycle_found;

  wait_for_graph_cycle_detector DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_waiter       (in_waiter),
    .in_owner        (in_owner),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cycle_found (out_cycle_found)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One row of the directed table. When known is set, cyc is the answer typed
  // in by hand; otherwise the answer comes from the graph mirror below.
  typedef struct packed {
    logic       cmd;
    logic [2:0] waiter;
    logic [2:0] owner;
    logic       known;
    logic       cyc;
  } dir_row_t;

  dir_row_t directed_tab [DIR_N] = '{
    '{CMD_CLEAR, 3'd0, 3'd0, 1'b1, 1'b0},  // clearing an empty row straight after reset
    '{CMD_ADD,   3'd0, 3'd0, 1'b1, 1'b1},  // self-loop on the lowest node
    '{CMD_CLEAR, 3'd0, 3'd7, 1'b1, 1'b0},  // clear ignores the owner field
    '{CMD_ADD,   3'd7, 3'd7, 1'b1, 1'b1},  // self-loop on the highest node
    '{CMD_ADD,   3'd7, 3'd7, 1'b1, 1'b1},  // adding an edge that is already there
    '{CMD_CLEAR, 3'd7, 3'd0, 1'b1, 1'b0},
    '{CMD_ADD,   3'd0, 3'd7, 1'b0, 1'b0},
    '{CMD_ADD,   3'd7, 3'd0, 1'b0, 1'b0},  // two-node cycle
    '{CMD_CLEAR, 3'd7, 3'd7, 1'b0, 1'b0},
    '{CMD_ADD,   3'd1, 3'd2, 1'b0, 1'b0},  // chain 1..7, then closed back to 1
    '{CMD_ADD,   3'd2, 3'd3, 1'b0, 1'b0},
    '{CMD_ADD,   3'd3, 3'd4, 1'b0, 1'b0},
    '{CMD_ADD,   3'd4, 3'd5, 1'b0, 1'b0},
    '{CMD_ADD,   3'd5, 3'd6, 1'b0, 1'b0},
    '{CMD_ADD,   3'd6, 3'd7, 1'b0, 1'b0},
    '{CMD_ADD,   3'd7, 3'd1, 1'b0, 1'b0},
    '{CMD_CLEAR, 3'd4, 3'd5, 1'b0, 1'b0},  // break the long cycle in the middle
    '{CMD_ADD,   3'd4, 3'd0, 1'b0, 1'b0},  // reclose it through node 0
    '{CMD_ADD,   3'd3, 3'd5, 1'b0, 1'b0},  // shortcut 3 -> 5 closes another loop as well
    '{CMD_CLEAR, 3'd0, 3'd3, 1'b0, 1'b0},
    '{CMD_CLEAR, 3'd3, 3'd6, 1'b0, 1'b0}
  };

  // Mirror of the edge matrix: bit v of wait_rows[u] means u waits for v.
  wfg_pkg::matrix_t wait_rows   = '0;
  logic             cycle_expected [$];

  int in_idle_pct   = 0;
  int out_idle_pct  = 0;
  int words_sent    = 0;
  int mismatches    = 0;
  int hold_request  = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // Apply one event to the mirror, then peel sink nodes NODES times; any node
  // still alive afterwards sits on a directed cycle or can reach one.
  function automatic logic advance_graph(input logic cmd, input logic [2:0] w,
                                         input logic [2:0] o);
    wfg_pkg::row_t alive;
    wfg_pkg::row_t next_alive;
    if (int'(w) < wfg_pkg::NODES) begin
      if (cmd == CMD_ADD) begin
        if (int'(o) < wfg_pkg::NODES) wait_rows[w][o] = 1'b1;
      end else begin
        wait_rows[w] = '0;
      end
    end
    alive = '1;
    for (int r = 0; r < wfg_pkg::NODES; r++) begin
      next_alive = alive;
      for (int u = 0; u < wfg_pkg::NODES; u++) begin
        if (alive[u] && ((wait_rows[u] & alive) == '0)) next_alive[u] = 1'b0;
      end
      alive = next_alive;
    end
    return alive != '0;
  endfunction

  // Offer one event word, hold it until taken, then queue its answer.
  // Here in_valid is only lowered inside the gap loop, so a word that follows
  // straight on never sees two assignments in one step.
  task automatic send_event(input logic cmd, input logic [2:0] w, input logic [2:0] o,
                            input logic known, input logic cyc);
    logic pred;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_waiter <= w;
    in_owner  <= o;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = advance_graph(cmd, w, o);
    cycle_expected.push_back(known ? cyc : pred);
    words_sent++;
  endtask

  // Sender pause: drop valid and wait for every answer to come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cycle_expected.size() != 0) @(posedge clk);
  endtask

  // Receiver: checks each word taken, then picks the stall for the next cycle.
  // A bump of hold_request starts one long hold-off counted here.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_valid && !out_stall) begin
          if (cycle_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("unexpected result word: cycle_found=%0b", out_cycle_found);
          end else begin
            logic want;
            want = cycle_expected.pop_front();
            if (out_cycle_found !== want) begin
              mismatches++;
              if (mismatches <= 10)
                $display("cycle_found mismatch: expected %0b, got %0b", want,
                         out_cycle_found);
            end
          end
        end
      end
      if (hold_served != hold_request) begin
        hold_served = hold_request;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // Watchdog on cycles where no word moves on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;
    int start;
    int len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  = 23;
          out_idle_pct = 82;
        end
        1: begin
          in_idle_pct  = 82;
          out_idle_pct = 23;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
          // Receiver holds off while the sender keeps pushing, so the queue
          // and output register fill and in_stall has to rise.
          hold_request++;
        end
      endcase

      if (phase == 0) begin
        for (int i = 0; i < DIR_N; i++)
          send_event(directed_tab[i].cmd, directed_tab[i].waiter, directed_tab[i].owner,
                     directed_tab[i].known, directed_tab[i].cyc);
      end

      // Mix of lone events, rings of random length and full wipes, so the
      // graph keeps swinging between acyclic and deadlocked.
      while (words_sent < PHASE_WORDS * (phase + 1)) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          for (int u = 0; u < wfg_pkg::NODES; u++)
            send_event(CMD_CLEAR, 3'(u), 3'($urandom_range(7)), 1'b0, 1'b0);
        end else if (pick < 45) begin
          start = $urandom_range(7);
          len   = $urandom_range(1, wfg_pkg::NODES);
          for (int i = 0; i < len; i++)
            send_event(CMD_ADD, 3'((start + i) % wfg_pkg::NODES),
                       (i == len - 1) ? 3'(start) : 3'((start + i + 1) % wfg_pkg::NODES),
                       1'b0, 1'b0);
        end else if (pick < 75) begin
          send_event(CMD_ADD, 3'($urandom_range(7)), 3'($urandom_range(7)), 1'b0, 1'b0);
        end else begin
          send_event(CMD_CLEAR, 3'($urandom_range(7)), 3'($urandom_range(7)), 1'b0, 1'b0);
        end
      end

      drain_results();
    end

    // Let any stray word show itself before the verdict.
    repeat (wfg_pkg::NODES * 4) @(posedge clk);
    if (mismatches == 0 && cycle_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
